// ===== hdl/bcd_pkg.sv =====
// Shared types, register indexes and constants for the button click detector.
package bcd_pkg;

   localparam int TIME_W      = 32;
   localparam int MS_W        = 16;
   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 8;

   typedef logic [1:0] csr_index_type;

   localparam csr_index_type CSR_DEBOUNCE_MS = 2'd0;
   localparam csr_index_type CSR_CLICK_MS    = 2'd1;
   localparam csr_index_type CSR_PRESS_MS    = 2'd2;
   localparam csr_index_type CSR_ACTIVE_LOW  = 2'd3;

   localparam logic [MS_W-1:0] DEBOUNCE_MS_RESET = 16'd50;
   localparam logic [MS_W-1:0] CLICK_MS_RESET    = 16'd400;
   localparam logic [MS_W-1:0] PRESS_MS_RESET    = 16'd800;
   localparam logic            ACTIVE_LOW_RESET  = 1'b1;

   typedef enum logic [1:0] {
      EVENT_NONE   = 2'd0,
      EVENT_CLICK  = 2'd1,
      EVENT_DOUBLE = 2'd2,
      EVENT_LONG   = 2'd3
   } event_type;

   typedef struct packed {
      logic              we;
      csr_index_type     index;
      logic [MS_W-1:0]   wdata;
   } csr_wr_type;

   typedef struct packed {
      logic [TIME_W-1:0] now_ms;
      logic              raw_level;
   } item_type;

   typedef struct packed {
      logic      idle;
      logic      stable_pressed;
      event_type event_res;
   } result_type;

endpackage

// ===== hdl/bcd_core.sv =====
// Debounce filter, click state machine and setting registers.
module bcd_core
   import bcd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  csr_wr_type csr_wr,
   input  logic       step,
   input  item_type   item,
   output result_type result
);

   typedef enum logic [2:0] {
      ST_WAIT     = 3'd0,
      ST_DOWN     = 3'd1,
      ST_UP       = 3'd2,
      ST_COUNT    = 3'd3,
      ST_HOLD     = 3'd4,
      ST_HOLD_END = 3'd5
   } state_type;

   logic [MS_W-1:0]   debounce_ms_ff;
   logic [MS_W-1:0]   click_ms_ff;
   logic [MS_W-1:0]   press_ms_ff;
   logic              active_low_ff;

   state_type         state_ff, state_in;
   logic              debounced_ff, debounced_in;
   logic              last_seen_ff, last_seen_in;
   logic [TIME_W-1:0] last_change_ff, last_change_in;
   logic [TIME_W-1:0] phase_start_ff, phase_start_in;
   logic [1:0]        click_count_ff, click_count_in;

   logic              pressed;
   logic              act;
   logic [TIME_W-1:0] change_wait;
   logic [TIME_W-1:0] phase_wait;
   event_type         event_code;

   always_comb begin
      pressed        = item.raw_level ^ active_low_ff;
      change_wait    = item.now_ms - last_change_ff;
      phase_wait     = item.now_ms - phase_start_ff;
      debounced_in   = debounced_ff;
      last_seen_in   = last_seen_ff;
      last_change_in = last_change_ff;
      state_in       = state_ff;
      phase_start_in = phase_start_ff;
      click_count_in = click_count_ff;
      event_code     = EVENT_NONE;

      if (last_seen_ff == pressed) begin
         if (change_wait >= {{(TIME_W-MS_W){1'b0}}, debounce_ms_ff}) begin
            debounced_in = pressed;
         end
      end else begin
         last_change_in = item.now_ms;
         last_seen_in   = pressed;
      end
      act = debounced_in;

      case (state_ff)
         ST_WAIT: begin
            if (act) begin
               state_in       = ST_DOWN;
               phase_start_in = item.now_ms;
               click_count_in = 2'd0;
            end
         end
         ST_DOWN: begin
            if (!act) begin
               state_in       = ST_UP;
               phase_start_in = item.now_ms;
            end else if (phase_wait > {{(TIME_W-MS_W){1'b0}}, press_ms_ff}) begin
               event_code = EVENT_LONG;
               state_in   = ST_HOLD;
            end
         end
         ST_UP: begin
            // count saturates at 3: three or more presses, never reported
            if (click_count_ff != 2'd3) begin
               click_count_in = click_count_ff + 2'd1;
            end
            state_in = ST_COUNT;
         end
         ST_COUNT: begin
            if (act) begin
               state_in       = ST_DOWN;
               phase_start_in = item.now_ms;
            end else if (phase_wait >= {{(TIME_W-MS_W){1'b0}}, click_ms_ff}
                         || click_count_ff == 2'd2) begin
               if (click_count_ff == 2'd1) begin
                  event_code = EVENT_CLICK;
               end else if (click_count_ff == 2'd2) begin
                  event_code = EVENT_DOUBLE;
               end
               state_in       = ST_WAIT;
               click_count_in = 2'd0;
               phase_start_in = '0;
            end
         end
         ST_HOLD: begin
            if (!act) begin
               state_in       = ST_HOLD_END;
               phase_start_in = item.now_ms;
            end
         end
         ST_HOLD_END: begin
            state_in       = ST_WAIT;
            click_count_in = 2'd0;
            phase_start_in = '0;
         end
         default: begin
            state_in = ST_WAIT;
         end
      endcase

      result.event_res      = event_code;
      result.stable_pressed = debounced_in;
      result.idle           = (state_in == ST_WAIT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ms_ff <= DEBOUNCE_MS_RESET;
         click_ms_ff    <= CLICK_MS_RESET;
         press_ms_ff    <= PRESS_MS_RESET;
         active_low_ff  <= ACTIVE_LOW_RESET;
         state_ff       <= ST_WAIT;
         debounced_ff   <= 1'b0;
         last_seen_ff   <= 1'b0;
         last_change_ff <= '0;
         phase_start_ff <= '0;
         click_count_ff <= 2'd0;
      end else begin
         if (csr_wr.we) begin
            case (csr_wr.index)
               CSR_DEBOUNCE_MS: debounce_ms_ff <= csr_wr.wdata;
               CSR_CLICK_MS:    click_ms_ff    <= csr_wr.wdata;
               CSR_PRESS_MS:    press_ms_ff    <= csr_wr.wdata;
               CSR_ACTIVE_LOW:  active_low_ff  <= csr_wr.wdata[0];
               default: begin
               end
            endcase
         end
         if (step) begin
            state_ff       <= state_in;
            debounced_ff   <= debounced_in;
            last_seen_ff   <= last_seen_in;
            last_change_ff <= last_change_in;
            phase_start_ff <= phase_start_in;
            click_count_ff <= click_count_in;
         end
      end
   end

endmodule

// ===== hdl/button_click_detector_unit.sv =====
// Push-button click detector: input register, detector core, result register.
//
// Usage:
//   req channel: one poll of the button per item, pin level and millisecond
//   timestamp. rsp channel: one result item per poll, carrying the event code
//   (none, click, double click, long press start), the debounced pressed
//   level and whether the click machine is back in its waiting state.
//   csr port: write-only settings (debounce, click and long-press times,
//   pin polarity), written while no poll is in flight.
// Path: the req item is taken into the input register, then, once the result
//   register is free or being taken, moves through the debounce filter and
//   click machine into the result register, which drives rsp_tvalid.
// Throughput: 1 item per cycle while rsp_tready is high; the state update of a
//   poll completes in the cycle it enters the result register, so the next follows.
// Reset: synchronous; clears the pipeline valids, the click machine and the
//   debounce history, and loads the settings with 50, 400, 800 ms, active low.
// Stall: while rsp_tready is low the result is held; one more poll waits in
//   the input register, after which req_tready drops.
module button_click_detector_unit
   import bcd_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // [0] raw_level, [32:1] now_ms
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,   // [1:0] event_res, [2] stable_pressed, [3] idle
   input  logic                   csr_we,
   input  csr_index_type          csr_index,
   input  logic [MS_W-1:0]        csr_wdata
);

   logic       req_valid_ff, req_valid_in;
   item_type   req_item_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_result_ff;
   result_type core_result;
   csr_wr_type csr_wr;
   logic       advance;
   logic       req_accept;

   assign advance    = req_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !req_valid_ff || advance;
   assign req_accept = req_tvalid && req_tready;

   assign csr_wr.we    = csr_we;
   assign csr_wr.index = csr_index;
   assign csr_wr.wdata = csr_wdata;

   always_comb begin
      req_valid_in = req_valid_ff;
      if (req_accept) begin
         req_valid_in = 1'b1;
      end else if (advance) begin
         req_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   bcd_core u_core (
      .clock  (clock),
      .reset  (reset),
      .csr_wr (csr_wr),
      .step   (advance),
      .item   (req_item_ff),
      .result (core_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (req_accept) begin
         req_item_ff.raw_level <= req_tdata[0];
         req_item_ff.now_ms    <= req_tdata[TIME_W:1];
      end
      if (advance) begin
         rsp_result_ff <= core_result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W-4){1'b0}}, rsp_result_ff.idle,
                        rsp_result_ff.stable_pressed, rsp_result_ff.event_res};

   a_long_press_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_result_ff.event_res == EVENT_LONG
      |-> !rsp_result_ff.idle && rsp_result_ff.stable_pressed)
      else $error("long press reported while idle or released");

   a_click_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_result_ff.event_res == EVENT_CLICK ||
                       rsp_result_ff.event_res == EVENT_DOUBLE)
      |-> rsp_result_ff.idle && !rsp_result_ff.stable_pressed)
      else $error("click reported without return to waiting");

   a_item_held: assert property (@(posedge clock) disable iff (reset)
      req_valid_ff && !advance |=> req_valid_ff && $stable(req_item_ff))
      else $error("pending item lost or changed");

   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("advanced item produced no result");

endmodule
